### rtl/core/mpe_pkg.sv
// Shared types and constants for the matrix multiply / power engine.
// Used by mpe_store, mpe_dp, mpe_seq and matrix_multiply_power_engine_top.
package mpe_pkg;

   localparam int DEF_MAX_DIM   = 8;
   localparam int DEF_FRAC_BITS = 16;

   localparam int ELEM_W      = 32;
   localparam int ACC_W       = 64;
   localparam int DIM_REG_W   = 4;
   localparam int EXP_W       = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_MODE      = 3'd0;
   localparam csr_index_type CSR_A_ROWS    = 3'd1;
   localparam csr_index_type CSR_INNER_DIM = 3'd2;
   localparam csr_index_type CSR_B_COLS    = 3'd3;
   localparam csr_index_type CSR_EXPONENT  = 3'd4;

   typedef logic [1:0] lsrc_type;

   localparam lsrc_type LSRC_A     = 2'd0;
   localparam lsrc_type LSRC_BANK  = 2'd1;
   localparam lsrc_type LSRC_IDENT = 2'd2;

   typedef logic [1:0] rsrc_type;

   localparam rsrc_type RSRC_B   = 2'd0;
   localparam rsrc_type RSRC_A   = 2'd1;
   localparam rsrc_type RSRC_ONE = 2'd2;

   typedef struct packed {
      logic     valid;
      logic     first;
      logic     last;
      logic     out_last;
      logic     ident_one;
      logic     to_out;
      logic     wbank;
      lsrc_type lsrc;
      rsrc_type rsrc;
   } issue_type;

endpackage

### rtl/core/mpe_store.sv
// Element memories: matrix A (two read ports), matrix B, and the two-bank work store.
// Reads are registered and advance with the datapath. Depends on mpe_pkg.
module mpe_store #(
   parameter int MAX_DIM = mpe_pkg::DEF_MAX_DIM
) (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic                            a_wr_en,
   input  logic                            b_wr_en,
   input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] ld_addr,
   input  logic [mpe_pkg::ELEM_W-1:0]      ld_data,
   input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] l_addr,
   input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] r_addr,
   input  logic                            rbank,
   input  logic                            bk_we,
   input  logic [$clog2(MAX_DIM*MAX_DIM):0]   bk_waddr,
   input  logic [mpe_pkg::ELEM_W:0]        bk_wdata,
   output logic [mpe_pkg::ELEM_W-1:0]      a_l_q,
   output logic [mpe_pkg::ELEM_W-1:0]      a_r_q,
   output logic [mpe_pkg::ELEM_W-1:0]      b_q,
   output logic [mpe_pkg::ELEM_W:0]        bk_q
);

   localparam int CELLS = MAX_DIM * MAX_DIM;

   logic [mpe_pkg::ELEM_W-1:0] store_a    [CELLS];
   logic [mpe_pkg::ELEM_W-1:0] store_b    [CELLS];
   logic [mpe_pkg::ELEM_W:0]   work_store [2*CELLS];

   always_ff @(posedge clock) begin
      if (a_wr_en) begin
         store_a[ld_addr] <= ld_data;
      end
      if (rd_en) begin
         a_l_q <= store_a[l_addr];
         a_r_q <= store_a[r_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (b_wr_en) begin
         store_b[ld_addr] <= ld_data;
      end
      if (rd_en) begin
         b_q <= store_b[r_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (bk_we) begin
         work_store[bk_waddr] <= bk_wdata;
      end
      if (rd_en) begin
         bk_q <= work_store[{rbank, l_addr}];
      end
   end

endmodule

### rtl/core/mpe_dp.sv
// Shared multiply-accumulate pipeline: operand select, 32x32 multiply, saturating
// 64-bit accumulate, round and saturate, result register. Depends on mpe_pkg.
module mpe_dp #(
   parameter int MAX_DIM   = mpe_pkg::DEF_MAX_DIM,
   parameter int FRAC_BITS = mpe_pkg::DEF_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mpe_pkg::issue_type                    issue,
   input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    waddr,
   input  logic [mpe_pkg::ELEM_W-1:0]            a_l_q,
   input  logic [mpe_pkg::ELEM_W-1:0]            a_r_q,
   input  logic [mpe_pkg::ELEM_W-1:0]            b_q,
   input  logic [mpe_pkg::ELEM_W:0]              bk_q,
   output logic                                  adv,
   output logic                                  busy,
   output logic                                  bk_we,
   output logic [$clog2(MAX_DIM*MAX_DIM):0]      bk_waddr,
   output logic [mpe_pkg::ELEM_W:0]              bk_wdata,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [mpe_pkg::ELEM_W-1:0]     rsp_out_value,
   output logic                                  rsp_out_last,
   output logic                                  rsp_saturated
);

   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
   localparam int EW     = mpe_pkg::ELEM_W;
   localparam int AW     = mpe_pkg::ACC_W;

   localparam logic signed [EW-1:0] ONE_Q   = EW'(1) << FRAC_BITS;
   localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
   localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};
   localparam logic signed [AW:0]   Q_MAX   = 65'sd2147483647;
   localparam logic signed [AW:0]   Q_MIN   = -65'sd2147483648;

   mpe_pkg::issue_type p1_ff, p2_ff, p3_ff;
   logic [ADDR_W-1:0]  w1_ff, w2_ff, w3_ff;

   logic signed [EW-1:0] left_op, right_op;
   logic                 lsat;
   logic signed [AW-1:0] prod_in, prod_ff;
   logic                 lsat2_ff;

   logic signed [AW-1:0] acc_base, acc_in, acc_ff;
   logic signed [AW:0]   acc_sum;
   logic                 acc_ovf;
   logic                 fl_in, fl_ff;

   logic signed [AW:0]   acc_ext, q;
   logic signed [EW-1:0] res_value;
   logic                 res_sat;

   logic                 rsp_valid_in, rsp_valid_ff;
   logic signed [EW-1:0] rsp_value_ff;
   logic                 rsp_last_ff, rsp_sat_ff;

   assign adv  = !rsp_valid_ff || !rsp_stall;
   assign busy = p1_ff.valid || p2_ff.valid || p3_ff.valid;

   always_comb begin
      lsat = 1'b0;
      unique case (p1_ff.lsrc)
         mpe_pkg::LSRC_A:     left_op = a_l_q;
         mpe_pkg::LSRC_BANK: begin
            left_op = bk_q[EW-1:0];
            lsat    = bk_q[EW];
         end
         mpe_pkg::LSRC_IDENT: left_op = p1_ff.ident_one ? ONE_Q : '0;
         default:             left_op = '0;
      endcase
      unique case (p1_ff.rsrc)
         mpe_pkg::RSRC_B:   right_op = b_q;
         mpe_pkg::RSRC_A:   right_op = a_r_q;
         mpe_pkg::RSRC_ONE: right_op = ONE_Q;
         default:           right_op = '0;
      endcase
   end

   assign prod_in = left_op * right_op;

   always_comb begin
      acc_base = p2_ff.first ? '0 : acc_ff;
      acc_sum  = {acc_base[AW-1], acc_base} + {prod_ff[AW-1], prod_ff};
      acc_ovf  = acc_sum[AW] ^ acc_sum[AW-1];
      if (acc_ovf) begin
         acc_in = acc_sum[AW] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_in = acc_sum[AW-1:0];
      end
      fl_in = (!p2_ff.first && fl_ff) || acc_ovf || lsat2_ff;
   end

   assign acc_ext = {acc_ff[AW-1], acc_ff};

   generate
      if (FRAC_BITS == 0) begin : g_round_none
         assign q = acc_ext;
      end else begin : g_round_half_up
         assign q = (acc_ext >>> FRAC_BITS) + $signed({{AW{1'b0}}, acc_ff[FRAC_BITS-1]});
      end
   endgenerate

   always_comb begin
      res_sat = fl_ff;
      priority if (q > Q_MAX) begin
         res_value = {1'b0, {(EW-1){1'b1}}};
         res_sat   = 1'b1;
      end else if (q < Q_MIN) begin
         res_value = {1'b1, {(EW-1){1'b0}}};
         res_sat   = 1'b1;
      end else begin
         res_value = q[EW-1:0];
      end
   end

   assign rsp_valid_in = p3_ff.valid && p3_ff.last && p3_ff.to_out;

   assign bk_we    = adv && p3_ff.valid && p3_ff.last && !p3_ff.to_out;
   assign bk_waddr = {p3_ff.wbank, w3_ff};
   assign bk_wdata = {res_sat, res_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff        <= '0;
         p2_ff        <= '0;
         p3_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_ff        <= issue;
         p2_ff        <= p1_ff;
         p3_ff        <= p2_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w1_ff    <= waddr;
         w2_ff    <= w1_ff;
         w3_ff    <= w2_ff;
         prod_ff  <= prod_in;
         lsat2_ff <= lsat;
         if (p2_ff.valid) begin
            acc_ff <= acc_in;
            fl_ff  <= fl_in;
         end
         if (rsp_valid_in) begin
            rsp_value_ff <= res_value;
            rsp_last_ff  <= p3_ff.out_last;
            rsp_sat_ff   <= res_sat;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_last  = rsp_last_ff;
   assign rsp_saturated = rsp_sat_ff;

`ifndef SYNTHESIS
   a_acc_chain: assert property (@(posedge clock) disable iff (reset)
      p2_ff.valid && !p2_ff.first |-> p3_ff.valid)
      else $error("accumulate term without its predecessor");

   a_elem_boundary: assert property (@(posedge clock) disable iff (reset)
      p1_ff.valid && p1_ff.first && p2_ff.valid |-> p2_ff.last)
      else $error("new element started before previous one closed");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(p3_ff.valid && p3_ff.last && p3_ff.to_out))
      else $error("result register loaded without finished element");
`endif

endmodule

### rtl/core/mpe_seq.sv
// Sequencer: configuration registers, load counters, and the pass / row / column /
// inner-index counters that feed the shared MAC pipeline. Depends on mpe_pkg.
module mpe_seq #(
   parameter int MAX_DIM = mpe_pkg::DEF_MAX_DIM
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_matrix_select,
   input  logic                                  csr_we,
   input  mpe_pkg::csr_index_type                csr_index,
   input  logic [mpe_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                  adv,
   input  logic                                  busy,
   output logic                                  a_wr_en,
   output logic                                  b_wr_en,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    ld_addr,
   output mpe_pkg::issue_type                    issue,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    l_addr,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    r_addr,
   output logic                                  rbank,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    waddr
);

   localparam int CELLS  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int RW     = mpe_pkg::DIM_REG_W;
   localparam int XW     = mpe_pkg::EXP_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   function automatic logic [DIM_W-1:0] dim_of(input logic [RW-1:0] r);
      logic [DIM_W-1:0] d;
      if (r == '0) begin
         d = DIM_W'(1);
      end else if (r > RW'(MAX_DIM)) begin
         d = DIM_W'(MAX_DIM);
      end else begin
         d = DIM_W'(r);
      end
      return d;
   endfunction

   logic [1:0]        state_ff, state_in;
   logic              mode_ff, mode_in;
   logic [RW-1:0]     a_rows_ff, a_rows_in, inner_dim_ff, inner_dim_in, b_cols_ff, b_cols_in;
   logic [XW-1:0]     exponent_ff, exponent_in;
   logic [CNT_W-1:0]  count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic [XW-1:0]     pass_ff, pass_in;
   logic [IDX_W-1:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [ADDR_W-1:0] elem_ff, elem_in, l_base_ff, l_base_in, l_addr_ff, l_addr_in;
   logic [ADDR_W-1:0] r_addr_ff, r_addr_in;

   logic [DIM_W-1:0]  n, m, p, rows, cols, inner;
   logic [CNT_W-1:0]  need_a, need_b, a_next, b_next;
   mpe_pkg::lsrc_type lsrc;
   mpe_pkg::rsrc_type rsrc;
   logic              to_out, stream, more_passes;
   logic              take, start, last_k, last_j, last_i;

   assign n = dim_of(a_rows_ff);
   assign m = dim_of(inner_dim_ff);
   assign p = dim_of(b_cols_ff);

   assign need_a = mode_ff ? CNT_W'(n) * CNT_W'(n) : CNT_W'(n) * CNT_W'(m);
   assign need_b = mode_ff ? '0 : CNT_W'(m) * CNT_W'(p);

   always_comb begin
      rows   = n;
      cols   = p;
      inner  = m;
      lsrc   = mpe_pkg::LSRC_A;
      rsrc   = mpe_pkg::RSRC_B;
      to_out = 1'b1;
      stream = 1'b0;
      if (mode_ff) begin
         cols = n;
         priority if (exponent_ff == '0) begin
            lsrc   = mpe_pkg::LSRC_IDENT;
            rsrc   = mpe_pkg::RSRC_ONE;
            inner  = DIM_W'(1);
            stream = 1'b1;
         end else if (exponent_ff == XW'(1)) begin
            rsrc   = mpe_pkg::RSRC_ONE;
            inner  = DIM_W'(1);
            stream = 1'b1;
         end else begin
            inner  = n;
            rsrc   = mpe_pkg::RSRC_A;
            lsrc   = (pass_ff == XW'(1)) ? mpe_pkg::LSRC_A : mpe_pkg::LSRC_BANK;
            to_out = (pass_ff == exponent_ff - XW'(1));
         end
      end
   end

   assign more_passes = mode_ff && (exponent_ff > XW'(1)) && !to_out;

   assign take    = req_valid && (state_ff == ST_IDLE);
   assign a_wr_en = take && !req_matrix_select && (count_a_ff < need_a);
   assign b_wr_en = take && req_matrix_select && !mode_ff && (count_b_ff < need_b);
   assign a_next  = count_a_ff + CNT_W'(a_wr_en);
   assign b_next  = count_b_ff + CNT_W'(b_wr_en);
   assign start   = take && (a_next >= need_a) && (b_next >= need_b);
   assign ld_addr = a_wr_en ? count_a_ff[ADDR_W-1:0] : count_b_ff[ADDR_W-1:0];

   assign last_k = (k_ff == IDX_W'(inner - DIM_W'(1)));
   assign last_j = (j_ff == IDX_W'(cols - DIM_W'(1)));
   assign last_i = (i_ff == IDX_W'(rows - DIM_W'(1)));

   always_comb begin
      issue.valid     = (state_ff == ST_RUN);
      issue.first     = (k_ff == '0);
      issue.last      = last_k;
      issue.out_last  = last_k && last_j && last_i;
      issue.ident_one = (i_ff == j_ff);
      issue.to_out    = to_out;
      issue.wbank     = ~pass_ff[0];
      issue.lsrc      = lsrc;
      issue.rsrc      = rsrc;
   end

   assign l_addr    = stream ? elem_ff : l_addr_ff;
   assign r_addr    = r_addr_ff;
   assign rbank     = pass_ff[0];
   assign waddr     = elem_ff;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      a_rows_in    = a_rows_ff;
      inner_dim_in = inner_dim_ff;
      b_cols_in    = b_cols_ff;
      exponent_in  = exponent_ff;
      count_a_in   = a_next;
      count_b_in   = b_next;
      pass_in      = pass_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      elem_in      = elem_ff;
      l_base_in    = l_base_ff;
      l_addr_in    = l_addr_ff;
      r_addr_in    = r_addr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               count_a_in = '0;
               count_b_in = '0;
               pass_in    = XW'(1);
               state_in   = ST_RUN;
               i_in       = '0;
               j_in       = '0;
               k_in       = '0;
               elem_in    = '0;
               l_base_in  = '0;
               l_addr_in  = '0;
               r_addr_in  = '0;
            end
         end
         ST_RUN: begin
            if (adv) begin
               if (!last_k) begin
                  k_in      = k_ff + IDX_W'(1);
                  l_addr_in = l_addr_ff + ADDR_W'(1);
                  r_addr_in = r_addr_ff + ADDR_W'(cols);
               end else begin
                  k_in    = '0;
                  elem_in = elem_ff + ADDR_W'(1);
                  if (!last_j) begin
                     j_in      = j_ff + IDX_W'(1);
                     l_addr_in = l_base_ff;
                     r_addr_in = ADDR_W'(j_ff) + ADDR_W'(1);
                  end else begin
                     j_in      = '0;
                     r_addr_in = '0;
                     if (!last_i) begin
                        i_in      = i_ff + IDX_W'(1);
                        l_base_in = l_base_ff + ADDR_W'(inner);
                        l_addr_in = l_base_ff + ADDR_W'(inner);
                     end else begin
                        state_in = ST_DRAIN;
                     end
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (!busy) begin
               if (more_passes) begin
                  pass_in   = pass_ff + XW'(1);
                  state_in  = ST_RUN;
                  i_in      = '0;
                  j_in      = '0;
                  k_in      = '0;
                  elem_in   = '0;
                  l_base_in = '0;
                  l_addr_in = '0;
                  r_addr_in = '0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_we) begin
         unique case (csr_index)
            mpe_pkg::CSR_MODE:      mode_in      = csr_wdata[0];
            mpe_pkg::CSR_A_ROWS:    a_rows_in    = csr_wdata[RW-1:0];
            mpe_pkg::CSR_INNER_DIM: inner_dim_in = csr_wdata[RW-1:0];
            mpe_pkg::CSR_B_COLS:    b_cols_in    = csr_wdata[RW-1:0];
            mpe_pkg::CSR_EXPONENT:  exponent_in  = csr_wdata[XW-1:0];
            default: ;
         endcase
         if (csr_index == mpe_pkg::CSR_MODE || csr_index == mpe_pkg::CSR_A_ROWS ||
             csr_index == mpe_pkg::CSR_INNER_DIM || csr_index == mpe_pkg::CSR_B_COLS ||
             csr_index == mpe_pkg::CSR_EXPONENT) begin
            count_a_in = '0;
            count_b_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b0;
         a_rows_ff    <= RW'(1);
         inner_dim_ff <= RW'(1);
         b_cols_ff    <= RW'(1);
         exponent_ff  <= XW'(1);
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         pass_ff      <= XW'(1);
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         elem_ff      <= '0;
         l_base_ff    <= '0;
         l_addr_ff    <= '0;
         r_addr_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         a_rows_ff    <= a_rows_in;
         inner_dim_ff <= inner_dim_in;
         b_cols_ff    <= b_cols_in;
         exponent_ff  <= exponent_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         pass_ff      <= pass_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         elem_ff      <= elem_in;
         l_base_ff    <= l_base_in;
         l_addr_ff    <= l_addr_in;
         r_addr_ff    <= r_addr_in;
      end
   end

`ifndef SYNTHESIS
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !busy)
      else $error("idle with transactions still in the pipeline");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_a_ff <= need_a && count_b_ff <= need_b)
      else $error("load count beyond matrix size");

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> ({1'b0, l_addr} < (ADDR_W+1)'(CELLS) &&
                              {1'b0, r_addr} < (ADDR_W+1)'(CELLS)))
      else $error("operand address out of range");
`endif

endmodule

### rtl/core/matrix_multiply_power_engine_top.sv
// Top level of the matrix multiply / integer power engine.
// Instantiates mpe_seq, mpe_store and mpe_dp; depends on mpe_pkg.
//
// Usage:
//   Set mode, a_rows, inner_dim, b_cols and exponent through the csr_ port while idle;
//   any listed register write discards a partial load. Send elements on the req_
//   channel in row-major order, matrix_select 0 for A and 1 for B (B only in multiply
//   mode). The transaction that completes the load starts the computation and
//   req_stall stays high until every result element has left the MAC pipeline.
//   Results leave on the rsp_ channel in row-major order; rsp_out_last marks the
//   final element and rsp_saturated flags any clipping behind that element.
//   One shared 32x32 multiplier with a 64-bit saturating accumulator does all work,
//   one multiply-accumulate per cycle while the sequencer runs and rsp_stall does not
//   hold the output; power mode runs exponent-1 passes through the two-bank work store,
//   or one streaming pass for exponent 0 or 1. Load elements are accepted back to back.
//   While rsp_stall holds a result in the output register the whole pipeline freezes.
//   Reset (synchronous) clears the registers to their defaults and empties the
//   pipeline; the element stores hold garbage until loaded.
module matrix_multiply_power_engine_top #(
   parameter int MAX_DIM   = mpe_pkg::DEF_MAX_DIM,
   parameter int FRAC_BITS = mpe_pkg::DEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_matrix_select,
   input  logic signed [mpe_pkg::ELEM_W-1:0]   req_element,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [mpe_pkg::ELEM_W-1:0]   rsp_out_value,
   output logic                                rsp_out_last,
   output logic                                rsp_saturated,
   input  logic                                csr_we,
   input  mpe_pkg::csr_index_type              csr_index,
   input  logic [mpe_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

   logic                      adv, busy;
   logic                      a_wr_en, b_wr_en;
   logic [ADDR_W-1:0]         ld_addr, l_addr, r_addr, waddr;
   logic                      rbank;
   mpe_pkg::issue_type        issue;
   logic [mpe_pkg::ELEM_W-1:0] a_l_q, a_r_q, b_q;
   logic [mpe_pkg::ELEM_W:0]  bk_q, bk_wdata;
   logic                      bk_we;
   logic [ADDR_W:0]           bk_waddr;

   mpe_seq #(
      .MAX_DIM (MAX_DIM)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_matrix_select (req_matrix_select),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .adv               (adv),
      .busy              (busy),
      .a_wr_en           (a_wr_en),
      .b_wr_en           (b_wr_en),
      .ld_addr           (ld_addr),
      .issue             (issue),
      .l_addr            (l_addr),
      .r_addr            (r_addr),
      .rbank             (rbank),
      .waddr             (waddr)
   );

   mpe_store #(
      .MAX_DIM (MAX_DIM)
   ) u_store (
      .clock    (clock),
      .rd_en    (adv),
      .a_wr_en  (a_wr_en),
      .b_wr_en  (b_wr_en),
      .ld_addr  (ld_addr),
      .ld_data  (req_element),
      .l_addr   (l_addr),
      .r_addr   (r_addr),
      .rbank    (rbank),
      .bk_we    (bk_we),
      .bk_waddr (bk_waddr),
      .bk_wdata (bk_wdata),
      .a_l_q    (a_l_q),
      .a_r_q    (a_r_q),
      .b_q      (b_q),
      .bk_q     (bk_q)
   );

   mpe_dp #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .issue         (issue),
      .waddr         (waddr),
      .a_l_q         (a_l_q),
      .a_r_q         (a_r_q),
      .b_q           (b_q),
      .bk_q          (bk_q),
      .adv           (adv),
      .busy          (busy),
      .bk_we         (bk_we),
      .bk_waddr      (bk_waddr),
      .bk_wdata      (bk_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_value (rsp_out_value),
      .rsp_out_last  (rsp_out_last),
      .rsp_saturated (rsp_saturated)
   );

endmodule
